### sv/ttsb_pkg.sv
// ----------------------------------------------------------------------------
// Text terminal package
// Shared geometry, control codes and command modes.
// ----------------------------------------------------------------------------
package ttsb_pkg;

  localparam int unsigned ScreenColumns = 80;
  localparam int unsigned ScreenRows    = 25;
  localparam int unsigned HistoryDepth  = 1024;
  localparam int unsigned TabStop       = 4;
  localparam int unsigned VtabStop      = 4;

  localparam int unsigned ColW  = 7;
  localparam int unsigned RowW  = 5;
  localparam int unsigned LiveN = ScreenColumns * ScreenRows;
  localparam int unsigned LiveW = $clog2(LiveN);
  localparam int unsigned HeadW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned HistN = HistoryDepth * ScreenColumns;
  localparam int unsigned HistW = $clog2(HistN);
  localparam int unsigned CntW  = 11;

  localparam logic [7:0] BlankChar  = 8'h20;
  localparam logic [7:0] ResetColor = 8'h0F;

  localparam logic [7:0] ChNl  = 8'h0A;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChVt  = 8'h0B;
  localparam logic [7:0] ChBel = 8'h07;

  localparam logic [2:0] ModePut    = 3'd0;
  localparam logic [2:0] ModeUp     = 3'd1;
  localparam logic [2:0] ModeDown   = 3'd2;
  localparam logic [2:0] ModeBottom = 3'd3;
  localparam logic [2:0] ModeColor  = 3'd4;
  localparam logic [2:0] ModeRead   = 3'd5;

endpackage

### sv/ttsb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module ttsb_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### sv/text_terminal_with_scrollback_core.sv
// ----------------------------------------------------------------------------
// Text terminal with scrollback
// Character-cell screen, cursor, colour and history ring in block memories.
// ----------------------------------------------------------------------------
// Each accepted beat goes through StOut to its result, a cell read via StRdH or
// StRdL first; a form feed first clears the live screen, a line save reads and writes
// each cell of the row, and a screen scroll then moves each cell up through the one
// read port of the live memory and blanks the last row. Throughput: one beat at a time;
// the next beat is taken once the result has been accepted. After reset a pass
// fills the live screen with blanks before the first beat is accepted.
module text_terminal_with_scrollback_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: mode[2:0], char_code[10:3], line_count[18:11], new_color[26:19],
  // cell_column[33:27], cell_row[38:34], zeros above
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: cell_entry[15:0], cursor_column[22:16], cursor_row[27:23],
  // view_offset[32:28], viewing_history[33], history_lines[44:34], zeros above
  output logic [47:0] m_axis_tdata
);
  localparam int unsigned LW = ttsb_pkg::LiveW;
  localparam int unsigned HW = ttsb_pkg::HistW;
  localparam int unsigned CW = ttsb_pkg::ColW;
  localparam int unsigned RW = ttsb_pkg::RowW;
  localparam int unsigned NW = ttsb_pkg::CntW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StClr   = 4'd1;
  localparam logic [3:0] StSaveR = 4'd2;
  localparam logic [3:0] StSaveW = 4'd3;
  localparam logic [3:0] StScrR  = 4'd4;
  localparam logic [3:0] StScrW  = 4'd5;
  localparam logic [3:0] StBlank = 4'd6;
  localparam logic [3:0] StRdH   = 4'd7;
  localparam logic [3:0] StRdL   = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StPost  = 4'd10;

  localparam logic [CW-1:0] LastCol = CW'(ttsb_pkg::ScreenColumns - 1);
  localparam logic [RW-1:0] LastRow = RW'(ttsb_pkg::ScreenRows - 1);

  logic [3:0]     st_q, st_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [7:0]     color_q, color_d;
  logic           view_q, view_d;
  logic [RW-1:0]  vl_q, vl_d;
  logic [ttsb_pkg::HeadW-1:0] head_q, head_d;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic [LW-1:0]  ptr_q, ptr_d;
  logic [CW-1:0]  x_q, x_d;
  logic [15:0]    entry_q, entry_d;
  logic           post_scroll_q, post_scroll_d;
  logic           nl_q, nl_d;
  logic           out_v_q;
  logic [47:0]    out_q;
  // Marks that StOut belongs to a beat rather than the power-up clear.
  logic           out_busy_q;

  logic [2:0]  in_mode;
  logic [7:0]  in_ch, in_lines, in_color;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  assign in_mode  = s_axis_tdata[2:0];
  assign in_ch    = s_axis_tdata[10:3];
  assign in_lines = s_axis_tdata[18:11];
  assign in_color = s_axis_tdata[26:19];
  assign in_col   = s_axis_tdata[33:27];
  assign in_row   = s_axis_tdata[38:34];

  logic          lwe, hwe;
  logic [LW-1:0] lwa, lra;
  logic [15:0]   lwd, lrd, hrd;
  logic [HW-1:0] hwa, hra;

  ttsb_ram #(.Depth(ttsb_pkg::LiveN), .Width(16)) u_live (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lra), .rdata_o(lrd));
  ttsb_ram #(.Depth(ttsb_pkg::HistN), .Width(16)) u_hist (
    .clk_i, .we_i(hwe), .waddr_i(hwa), .wdata_i(lrd), .raddr_i(hra), .rdata_o(hrd));

  function automatic logic [LW-1:0] laddr(logic [RW-1:0] r, logic [CW-1:0] c);
    laddr = LW'(r * ttsb_pkg::ScreenColumns) + LW'(c);
  endfunction

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == StIdle) && !out_v_q;

  logic [ttsb_pkg::HeadW-1:0] head_inc, hidx;
  assign head_inc = (32'(head_q) == ttsb_pkg::HistoryDepth - 1) ? '0 : head_q + 1'b1;
  assign hidx = ttsb_pkg::HeadW'((32'(head_q) + ttsb_pkg::HistoryDepth - 32'(vl_q)
                + 32'(in_row)) % ttsb_pkg::HistoryDepth);

  logic [8:0] vsum;
  logic [CW:0] tcol;
  logic [RW:0] trow;
  assign vsum = 9'(vl_q) + 9'(in_lines);
  assign tcol = (CW+1)'(col_q) + (CW+1)'(ttsb_pkg::TabStop - (32'(col_q) % ttsb_pkg::TabStop));
  assign trow = (RW+1)'(row_q) + (RW+1)'(ttsb_pkg::VtabStop - (32'(row_q) % ttsb_pkg::VtabStop));

  always_comb begin
    st_d = st_q; col_d = col_q; row_d = row_q; color_d = color_q; view_d = view_q;
    vl_d = vl_q; head_d = head_q; cnt_d = cnt_q; ptr_d = ptr_q; x_d = x_q;
    entry_d = entry_q; post_scroll_d = post_scroll_q; nl_d = nl_q;
    lwe = 1'b0; lwa = ptr_q; lwd = {ttsb_pkg::ResetColor, ttsb_pkg::BlankChar};
    lra = ptr_q; hwe = 1'b0;
    hwa = HW'(32'(head_q) * ttsb_pkg::ScreenColumns) + HW'(x_q);
    hra = '0;
    case (st_q)
      StIdle: if (accept) begin
        entry_d = '0;
        st_d = StOut;
        case (in_mode)
          ttsb_pkg::ModePut: begin
            view_d = 1'b0; vl_d = '0;
            case (in_ch)
              ttsb_pkg::ChNl: begin
                // The row is saved first; the cursor cell is blanked and the
                // cursor moved once the save is complete.
                nl_d = 1'b1;
                post_scroll_d = (row_q == LastRow);
                ptr_d = laddr(row_q, '0); x_d = '0; st_d = StSaveR;
              end
              ttsb_pkg::ChTab: col_d = (tcol > (CW+1)'(LastCol)) ? LastCol : CW'(tcol);
              ttsb_pkg::ChCr:  col_d = '0;
              ttsb_pkg::ChFf: begin
                col_d = '0; row_d = '0; color_d = ttsb_pkg::ResetColor;
                ptr_d = '0; st_d = StClr;
              end
              ttsb_pkg::ChBs: if (col_q != '0) col_d = col_q - 1'b1;
              ttsb_pkg::ChVt: row_d = (trow > (RW+1)'(LastRow)) ? LastRow : RW'(trow);
              ttsb_pkg::ChBel: ;
              default: begin
                lwe = 1'b1; lwa = laddr(row_q, col_q); lwd = {color_q, in_ch};
                if (col_q == LastCol) begin
                  col_d = '0;
                  if (row_q != LastRow) row_d = row_q + 1'b1;
                  else begin
                    post_scroll_d = 1'b1;
                    ptr_d = '0; x_d = '0; st_d = StSaveR;
                  end
                end else col_d = col_q + 1'b1;
              end
            endcase
          end
          ttsb_pkg::ModeUp: if (cnt_q != '0) begin
            view_d = 1'b1;
            if ({2'b0, vsum} > cnt_q) vl_d = RW'(cnt_q > NW'(ttsb_pkg::ScreenRows) ? NW'(ttsb_pkg::ScreenRows) : cnt_q);
            else vl_d = (vsum > 9'(ttsb_pkg::ScreenRows)) ? RW'(ttsb_pkg::ScreenRows) : RW'(vsum);
          end
          ttsb_pkg::ModeDown: if (view_q) begin
            if (in_lines >= 8'(vl_q)) begin vl_d = '0; view_d = 1'b0; end
            else vl_d = vl_q - RW'(in_lines);
          end
          ttsb_pkg::ModeBottom: begin view_d = 1'b0; vl_d = '0; end
          ttsb_pkg::ModeColor: color_d = in_color;
          ttsb_pkg::ModeRead:
            if (32'(in_col) < ttsb_pkg::ScreenColumns && 32'(in_row) < ttsb_pkg::ScreenRows) begin
              if (view_q && in_row < vl_q) begin
                hra = HW'(32'(hidx) * ttsb_pkg::ScreenColumns) + HW'(in_col);
                st_d = StRdH;
              end else begin
                lra = laddr(in_row - (view_q ? vl_q : '0), in_col);
                st_d = StRdL;
              end
            end
          default: ;
        endcase
      end
      StRdH: begin entry_d = hrd; st_d = StOut; end
      StRdL: begin entry_d = lrd; st_d = StOut; end
      StClr: begin
        lwe = 1'b1; lwa = ptr_q; ptr_d = ptr_q + 1'b1;
        if (32'(ptr_q) == ttsb_pkg::LiveN - 1) st_d = StOut;
      end
      // Row save: read a live cell, then write it to the history line.
      StSaveR: begin lra = ptr_q; st_d = StSaveW; end
      StSaveW: begin
        hwe = 1'b1;
        ptr_d = ptr_q + 1'b1; x_d = x_q + 1'b1; st_d = StSaveR;
        if (x_q == LastCol) begin
          head_d = head_inc;
          if (32'(cnt_q) < ttsb_pkg::HistoryDepth) cnt_d = cnt_q + 1'b1;
          if (nl_q) begin
            lwe = 1'b1; lwa = laddr(row_q, col_q);
            lwd = {color_q, ttsb_pkg::BlankChar};
            col_d = '0;
            if (row_q != LastRow) row_d = row_q + 1'b1;
          end
          if (post_scroll_q) begin ptr_d = LW'(ttsb_pkg::ScreenColumns); st_d = StScrR; end
          else st_d = StOut;
        end
      end
      // Scroll: move each cell up one row, then blank the last row.
      StScrR: begin lra = ptr_q; st_d = StScrW; end
      StScrW: begin
        lwe = 1'b1; lwa = ptr_q - LW'(ttsb_pkg::ScreenColumns); lwd = lrd;
        ptr_d = ptr_q + 1'b1;
        if (32'(ptr_q) == ttsb_pkg::LiveN - 1) begin
          ptr_d = LW'(ttsb_pkg::LiveN - ttsb_pkg::ScreenColumns); st_d = StBlank;
        end else st_d = StScrR;
      end
      StBlank: begin
        lwe = 1'b1; lwa = ptr_q; lwd = {color_q, ttsb_pkg::BlankChar};
        ptr_d = ptr_q + 1'b1;
        if (32'(ptr_q) == ttsb_pkg::LiveN - 1) st_d = StOut;
      end
      StOut: begin post_scroll_d = 1'b0; nl_d = 1'b0; st_d = StIdle; end
      StPost: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; col_q <= '0; row_q <= '0; color_q <= ttsb_pkg::ResetColor;
      view_q <= 1'b0; vl_q <= '0; head_q <= '0; cnt_q <= '0; ptr_q <= '0; x_q <= '0;
      post_scroll_q <= 1'b0; nl_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; col_q <= col_d; row_q <= row_d; color_q <= color_d;
      view_q <= view_d; vl_q <= vl_d; head_q <= head_d; cnt_q <= cnt_d;
      ptr_q <= ptr_d; x_q <= x_d; post_scroll_q <= post_scroll_d; nl_q <= nl_d;
      if (st_q == StOut && out_busy_q) out_v_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_busy_q <= 1'b0;
    else if (accept) out_busy_q <= 1'b1;
    else if (st_q == StOut) out_busy_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (st_q == StOut)
      out_q <= {3'b0, cnt_q, view_q, vl_q, row_q, col_q, entry_q};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready) else $error("beat taken while busy");
  a_view_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(vl_q) <= ttsb_pkg::ScreenRows) else $error("view beyond screen");
  a_view_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !view_q |-> (vl_q == '0)) else $error("view lines without view mode");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= ttsb_pkg::HistoryDepth) else $error("history count overflow");
`endif
endmodule
